// File: rtl/cbps_pkg.sv
package cbps_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 16;

  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int T_FRAC     = 16;
  localparam int T_W        = T_FRAC + 1;
  localparam int LAST_W     = $clog2(MAX_POINTS);
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = T_FRAC / DIV_BITS;
  localparam int COEF_W     = COORD_BITS + 4;
  localparam int PROD_W     = COEF_W + T_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int V_W        = SUM_W - T_FRAC;
  localparam int NUM_REGS   = 8;
  localparam int ADDR_W     = $clog2(NUM_REGS) + 2;
  localparam int DATA_W     = 32;

  localparam logic signed [V_W-1:0] V_MAX = V_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [V_W-1:0] V_MIN = V_W'(-(1 << (COORD_BITS - 1)));

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0] point_index;
    logic [CNT_W-1:0] point_count;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] curve_x;
    logic signed [COORD_BITS-1:0] curve_y;
    logic                         final_point;
    logic                         count_error;
  } out_word_t;

  typedef struct packed {
    logic fin;
    logic err;
  } ctl_t;

  typedef struct packed {
    logic [LAST_W-1:0] last;
    logic [LAST_W-1:0] rem;
    logic [T_W-1:0]    quot;
  } div_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] e;
    logic signed [COEF_W-1:0] f;
  } pre_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_t;

  function automatic div_t div_step(div_t d);
    div_t             o;
    logic [LAST_W:0]  r2;
    o = d;
    for (int i = 0; i < DIV_BITS; i++) begin
      r2 = {o.rem, 1'b0};
      if (r2 >= {1'b0, o.last}) begin
        r2     = r2 - {1'b0, o.last};
        o.quot = {o.quot[T_W-2:0], 1'b1};
      end else begin
        o.quot = {o.quot[T_W-2:0], 1'b0};
      end
      o.rem = r2[LAST_W-1:0];
    end
    return o;
  endfunction

  function automatic pre_t pre_coef(logic [COORD_BITS-1:0] p0, logic [COORD_BITS-1:0] p1,
                                    logic [COORD_BITS-1:0] p2, logic [COORD_BITS-1:0] p3);
    pre_t                     o;
    logic signed [COEF_W-1:0] d10;
    logic signed [COEF_W-1:0] d21;
    d10 = COEF_W'($signed(p1)) - COEF_W'($signed(p0));
    d21 = COEF_W'($signed(p2)) - COEF_W'($signed(p1));
    o.c = (d10 <<< 1) + d10;
    o.e = (d21 <<< 1) + d21;
    o.f = COEF_W'($signed(p3)) - COEF_W'($signed(p0));
    return o;
  endfunction

  function automatic coef_t fin_coef(pre_t p);
    coef_t o;
    o.a = p.f - p.e;
    o.b = p.e - p.c;
    o.c = p.c;
    return o;
  endfunction

  function automatic logic signed [PROD_W-1:0] smul(logic signed [COEF_W-1:0] k,
                                                   logic [T_W-1:0] t);
    logic signed [PROD_W-1:0] ka;
    logic signed [PROD_W-1:0] ta;
    ka = PROD_W'(k);
    ta = $signed(PROD_W'(t));
    return ka * ta;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] trunc_sat(logic signed [SUM_W-1:0] s);
    logic signed [V_W-1:0] v;
    v = s[SUM_W-1:T_FRAC];
    if (s[SUM_W-1] && (|s[T_FRAC-1:0])) begin
      v = v + V_W'(1);
    end
    if (v > V_MAX) begin
      v = V_MAX;
    end else if (v < V_MIN) begin
      v = V_MIN;
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

// File: rtl/cubic_bezier_point_sampler.sv
// Channel  | Handshake                     | Word
// ---------+-------------------------------+--------------------------------------
// in       | in_valid_i / in_ready_o       | in_data_i  : point_index, point_count
// out      | out_valid_o / out_ready_i     | out_data_o : curve_x, curve_y, flags
// cfg      | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata: P0..P3 x/y
//
// One word per clock sustained while the output is not stalled. Stages: input stage, four radix-16
// divider stages for t, t and t^2, t^3, products, two adder stages, output register.
// Reset clears valid bits and control points; no clearing pass.
// A stalled output freezes the whole pipeline; in_ready_o follows it.
module cubic_bezier_point_sampler import cbps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int NST = DIV_STAGES + 7;

  logic [COORD_BITS-1:0] cfg_q [NUM_REGS];
  logic                  cfg_we;

  pre_t  pre_x_q, pre_y_q;
  coef_t coef_x_q, coef_y_q;

  logic  adv;
  logic  vld_q [NST];
  ctl_t  ctl_q [NST-1];
  div_t  div_q [DIV_STAGES+1];
  div_t  div_d;
  ctl_t  ctl_d;

  logic [T_W-1:0] t1_m1_q, t1_m2_q, t2_m1_q, t2_m2_q, t3_m2_q;
  logic signed [PROD_W-1:0] pa_x_q, pb_x_q, pc_x_q, pa_y_q, pb_y_q, pc_y_q;
  logic signed [SUM_W-1:0]  sab_x_q, scd_x_q, sab_y_q, scd_y_q;
  logic signed [SUM_W-1:0]  s_x_q, s_y_q;
  out_word_t                out_q;

  logic [2*T_W-1:0] sq_prod, cu_prod;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = DATA_W'(cfg_q[paddr[ADDR_W-1:2]]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_q[paddr[ADDR_W-1:2]] <= pwdata[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    pre_x_q  <= pre_coef(cfg_q[REG_P0_X], cfg_q[REG_P1_X], cfg_q[REG_P2_X], cfg_q[REG_P3_X]);
    pre_y_q  <= pre_coef(cfg_q[REG_P0_Y], cfg_q[REG_P1_Y], cfg_q[REG_P2_Y], cfg_q[REG_P3_Y]);
    coef_x_q <= fin_coef(pre_x_q);
    coef_y_q <= fin_coef(pre_y_q);
  end

  assign adv        = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    logic [CNT_W-1:0] cnt_c;
    logic [CNT_W-1:0] last_w;
    logic [CNT_W-1:0] idx_w;
    logic             at_end;
    cnt_c  = (int'(in_data_i.point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                         : in_data_i.point_count;
    last_w = cnt_c - CNT_W'(1);
    idx_w  = CNT_W'(in_data_i.point_index);
    at_end = (idx_w >= last_w);
    ctl_d.err   = (in_data_i.point_count < CNT_W'(2));
    ctl_d.fin   = at_end && !ctl_d.err;
    div_d.last  = LAST_W'(last_w);
    div_d.rem   = at_end ? '0 : LAST_W'(idx_w);
    div_d.quot  = T_W'(at_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= ctl_d;
      for (int i = 1; i < NST-1; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
      div_q[0] <= div_d;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        div_q[i] <= div_step(div_q[i-1]);
      end
    end
  end

  assign sq_prod = div_q[DIV_STAGES].quot * div_q[DIV_STAGES].quot;
  assign cu_prod = t2_m1_q * t1_m1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_m1_q <= div_q[DIV_STAGES].quot;
      t2_m1_q <= sq_prod[T_W+T_FRAC-1:T_FRAC];

      t1_m2_q <= t1_m1_q;
      t2_m2_q <= t2_m1_q;
      t3_m2_q <= cu_prod[T_W+T_FRAC-1:T_FRAC];

      pa_x_q <= smul(coef_x_q.a, t3_m2_q);
      pb_x_q <= smul(coef_x_q.b, t2_m2_q);
      pc_x_q <= smul(coef_x_q.c, t1_m2_q);
      pa_y_q <= smul(coef_y_q.a, t3_m2_q);
      pb_y_q <= smul(coef_y_q.b, t2_m2_q);
      pc_y_q <= smul(coef_y_q.c, t1_m2_q);

      sab_x_q <= SUM_W'(pa_x_q) + SUM_W'(pb_x_q);
      scd_x_q <= SUM_W'(pc_x_q) + (SUM_W'($signed(cfg_q[REG_P0_X])) <<< T_FRAC);
      sab_y_q <= SUM_W'(pa_y_q) + SUM_W'(pb_y_q);
      scd_y_q <= SUM_W'(pc_y_q) + (SUM_W'($signed(cfg_q[REG_P0_Y])) <<< T_FRAC);

      s_x_q <= sab_x_q + scd_x_q;
      s_y_q <= sab_y_q + scd_y_q;

      out_q.final_point <= ctl_q[NST-2].fin;
      out_q.count_error <= ctl_q[NST-2].err;
      out_q.curve_x     <= ctl_q[NST-2].err ? $signed(cfg_q[REG_P0_X]) : trunc_sat(s_x_q);
      out_q.curve_y     <= ctl_q[NST-2].err ? $signed(cfg_q[REG_P0_Y]) : trunc_sat(s_y_q);
    end
  end

  assign out_valid_o = vld_q[NST-1];
  assign out_data_o  = out_q;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cbps_pkg::*;

  localparam int     PIPE_LATENCY   = 11;
  localparam int     STALL_LIMIT    = 2000;
  localparam longint Q_ONE          = 64'sd65536;
  localparam longint COORD_HI       = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO       = -(64'sd1 <<< (COORD_BITS - 1));
  localparam int     RANDOM_CURVES  = 4;
  localparam int     POINTS_PER_SET = 102;

  logic              clk;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_word_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_word_t         out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic signed [COORD_BITS-1:0] ctrl_pt [NUM_REGS];
  out_word_t                    expected_points [$];
  int                           send_idle_pct;
  int                           recv_stall_pct;
  int                           mismatches;
  int                           points_seen;
  int                           quiet_cycles;

  cubic_bezier_point_sampler i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [COORD_BITS-1:0] bezier_axis(
      longint q0, longint q1, longint q2, longint q3, longint t1, longint t2, longint t3);
    longint lin;
    longint quad;
    longint cub;
    longint acc;
    longint v;
    lin  = 3 * (q1 - q0);
    quad = 3 * (q2 - q1) - lin;
    cub  = q3 - q0 - lin - quad;
    acc  = cub * t3 + quad * t2 + lin * t1 + q0 * Q_ONE;
    v    = acc / Q_ONE;
    if (v > COORD_HI) begin
      v = COORD_HI;
    end else if (v < COORD_LO) begin
      v = COORD_LO;
    end
    return COORD_BITS'(v);
  endfunction

  function automatic out_word_t predict_point(in_word_t w);
    out_word_t o;
    longint    idx;
    longint    cnt;
    longint    last;
    longint    t1;
    longint    t2;
    longint    t3;
    longint    px [4];
    longint    py [4];
    for (int i = 0; i < 4; i++) begin
      px[i] = ctrl_pt[2 * i];
      py[i] = ctrl_pt[2 * i + 1];
    end
    o   = '0;
    idx = longint'(w.point_index);
    cnt = longint'(w.point_count);
    if (cnt < 2) begin
      o.curve_x     = COORD_BITS'(px[0]);
      o.curve_y     = COORD_BITS'(py[0]);
      o.count_error = 1'b1;
      return o;
    end
    if (cnt > MAX_POINTS) begin
      cnt = MAX_POINTS;
    end
    last = cnt - 1;
    if (idx > last) begin
      idx = last;
    end
    t1 = (idx * Q_ONE) / last;
    t2 = (t1 * t1) / Q_ONE;
    t3 = (t2 * t1) / Q_ONE;
    o.curve_x     = bezier_axis(px[0], px[1], px[2], px[3], t1, t2, t3);
    o.curve_y     = bezier_axis(py[0], py[1], py[2], py[3], t1, t2, t3);
    o.final_point = (idx == last);
    return o;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s of point %0d: got %0d, expected %0d",
             field, points_seen, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        $display("unexpected point %0d: x %0d y %0d", points_seen,
                 int'(out_data_o.curve_x), int'(out_data_o.curve_y));
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (out_data_o.curve_x !== want.curve_x)
          report_mismatch("curve_x", int'(out_data_o.curve_x), int'(want.curve_x));
        if (out_data_o.curve_y !== want.curve_y)
          report_mismatch("curve_y", int'(out_data_o.curve_y), int'(want.curve_y));
        if (out_data_o.final_point !== want.final_point)
          report_mismatch("final_point", int'(out_data_o.final_point),
                          int'(want.final_point));
        if (out_data_o.count_error !== want.count_error)
          report_mismatch("count_error", int'(out_data_o.count_error),
                          int'(want.count_error));
      end
      points_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d points pending",
               quiet_cycles, expected_points.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_pressure(int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic send_point(int cnt, int idx);
    in_word_t w;
    w.point_count = CNT_W'(cnt);
    w.point_index = IDX_W'(idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk); while (!in_ready_o);
    expected_points.push_back(predict_point(w));
  endtask

  // hold the input low until every pending point has come back
  task automatic drain_points(int extra_cycles);
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic program_curve(logic signed [COORD_BITS-1:0] pts [NUM_REGS]);
    cfg_reg_e r;
    drain_points(PIPE_LATENCY + 4);
    for (int i = 0; i < NUM_REGS; i++) begin
      r = cfg_reg_e'(i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= {16'($urandom()), pts[i]};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      ctrl_pt[i] = pts[i];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [COORD_BITS-1:0] random_coord();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1:       return COORD_BITS'($urandom());
      2:       return COORD_BITS'($signed($urandom_range(1023)) - 512);
      default: return COORD_BITS'($signed($urandom_range(16383)) - 8192);
    endcase
  endfunction

  task automatic send_random_point();
    int cnt;
    int last;
    int idx;
    case ($urandom_range(9))
      0:       cnt = $urandom_range(1);
      1:       cnt = $urandom_range(8191, MAX_POINTS + 1);
      2:       cnt = $urandom_range(16, 2);
      default: cnt = $urandom_range(MAX_POINTS, 2);
    endcase
    last = (cnt > MAX_POINTS) ? MAX_POINTS - 1 : ((cnt > 0) ? cnt - 1 : 0);
    case ($urandom_range(3))
      0:       idx = last;
      1:       idx = $urandom_range(4095);
      default: idx = $urandom_range(last);
    endcase
    send_point(cnt, idx);
  endtask

  task automatic test_reset_values();
    set_pressure(0, 0);
    send_point(MAX_POINTS, 1234);
    send_point(0, 77);
  endtask

  task automatic test_edge_cases();
    logic signed [COORD_BITS-1:0] pts [NUM_REGS];
    pts = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
            16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
    set_pressure(0, 0);
    program_curve(pts);
    send_point(0, 0);
    send_point(1, 4095);
    send_point(2, 0);
    send_point(2, 1);
    send_point(2, 4095);
    send_point(3, 1);
    send_point(MAX_POINTS, 0);
    send_point(MAX_POINTS, 2048);
    send_point(MAX_POINTS, 4095);
    send_point(MAX_POINTS + 1, 4095);
    send_point(8191, 0);
    send_point(8191, 4094);
    send_point(8191, 4095);
    send_point(4095, 4094);
    send_point(1000, 999);
    send_point(1000, 500);
    send_point(7, 3);
    send_point(5, 2730);
  endtask

  task automatic test_random_sweep(int idle_pct, int stall_pct);
    logic signed [COORD_BITS-1:0] pts [NUM_REGS];
    for (int k = 0; k < RANDOM_CURVES; k++) begin
      foreach (pts[i]) pts[i] = random_coord();
      program_curve(pts);
      set_pressure(idle_pct, stall_pct);
      for (int n = 0; n < POINTS_PER_SET; n++) begin
        if ($urandom_range(99) == 0) begin
          drain_points(0);
        end
        send_random_point();
      end
      set_pressure(0, 0);
    end
  endtask

  initial begin
    mismatches   = 0;
    points_seen  = 0;
    quiet_cycles = 0;
    foreach (ctrl_pt[i]) ctrl_pt[i] = '0;
    set_pressure(0, 0);
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_edge_cases();
    test_random_sweep(0, 0);
    test_random_sweep(73, 0);
    test_random_sweep(0, 73);
    test_random_sweep(20, 20);
    drain_points(PIPE_LATENCY + 4);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cbps_pkg.sv
rtl/cubic_bezier_point_sampler.sv
test/testbench.sv
